// ===== src/c6502_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c6502_pkg
// Shared types, opcode decode and constants for the 6502 subset core.
// ----------------------------------------------------------------------------
package c6502_pkg;

    localparam logic [15:0] START_ADDRESS_RESET = 16'h0000;

    typedef enum logic [3:0] {
        MODE_IMM  = 4'd0,
        MODE_ZP   = 4'd1,
        MODE_ZPX  = 4'd2,
        MODE_ZPY  = 4'd3,
        MODE_ABS  = 4'd4,
        MODE_ABSX = 4'd5,
        MODE_ABSY = 4'd6,
        MODE_INDX = 4'd7,
        MODE_INDY = 4'd8
    } t_mode;

    typedef enum logic [4:0] {
        OP_LDA = 5'd0,
        OP_LDX = 5'd1,
        OP_LDY = 5'd2,
        OP_STA = 5'd3,
        OP_STX = 5'd4,
        OP_STY = 5'd5,
        OP_AND = 5'd6,
        OP_ORA = 5'd7,
        OP_EOR = 5'd8,
        OP_ADC = 5'd9,
        OP_SBC = 5'd10,
        OP_CMP = 5'd11,
        OP_CPX = 5'd12,
        OP_CPY = 5'd13,
        OP_BIT = 5'd14
    } t_op;

    typedef struct packed {
        logic  legal;
        t_mode mode;
        t_op   op;
    } t_decode;

    localparam logic [7:0] FLAG_C = 8'h01;
    localparam logic [7:0] FLAG_Z = 8'h02;
    localparam logic [7:0] FLAG_V = 8'h40;
    localparam logic [7:0] FLAG_N = 8'h80;

    function automatic t_decode decode(input logic [7:0] code);
        t_decode d;
        d = '{legal: 1'b1, mode: MODE_IMM, op: OP_LDA};
        case (code)
            8'hA9: d = '{1'b1, MODE_IMM, OP_LDA};
            8'hA5: d = '{1'b1, MODE_ZP, OP_LDA};
            8'hB5: d = '{1'b1, MODE_ZPX, OP_LDA};
            8'hAD: d = '{1'b1, MODE_ABS, OP_LDA};
            8'hBD: d = '{1'b1, MODE_ABSX, OP_LDA};
            8'hB9: d = '{1'b1, MODE_ABSY, OP_LDA};
            8'hA1: d = '{1'b1, MODE_INDX, OP_LDA};
            8'hB1: d = '{1'b1, MODE_INDY, OP_LDA};
            8'hA2: d = '{1'b1, MODE_IMM, OP_LDX};
            8'hA6: d = '{1'b1, MODE_ZP, OP_LDX};
            8'hB6: d = '{1'b1, MODE_ZPY, OP_LDX};
            8'hAE: d = '{1'b1, MODE_ABS, OP_LDX};
            8'hBE: d = '{1'b1, MODE_ABSY, OP_LDX};
            8'hA0: d = '{1'b1, MODE_IMM, OP_LDY};
            8'hA4: d = '{1'b1, MODE_ZP, OP_LDY};
            8'hB4: d = '{1'b1, MODE_ZPX, OP_LDY};
            8'hAC: d = '{1'b1, MODE_ABS, OP_LDY};
            8'hBC: d = '{1'b1, MODE_ABSX, OP_LDY};
            8'h49: d = '{1'b1, MODE_IMM, OP_EOR};
            8'h45: d = '{1'b1, MODE_ZP, OP_EOR};
            8'h55: d = '{1'b1, MODE_ZPX, OP_EOR};
            8'h4D: d = '{1'b1, MODE_ABS, OP_EOR};
            8'h5D: d = '{1'b1, MODE_ABSX, OP_EOR};
            8'h59: d = '{1'b1, MODE_ABSY, OP_EOR};
            8'h41: d = '{1'b1, MODE_INDX, OP_EOR};
            8'h51: d = '{1'b1, MODE_INDY, OP_EOR};
            8'h29: d = '{1'b1, MODE_IMM, OP_AND};
            8'h25: d = '{1'b1, MODE_ZP, OP_AND};
            8'h35: d = '{1'b1, MODE_ZPX, OP_AND};
            8'h2D: d = '{1'b1, MODE_ABS, OP_AND};
            8'h3D: d = '{1'b1, MODE_ABSX, OP_AND};
            8'h39: d = '{1'b1, MODE_ABSY, OP_AND};
            8'h21: d = '{1'b1, MODE_INDX, OP_AND};
            8'h31: d = '{1'b1, MODE_INDY, OP_AND};
            8'h09: d = '{1'b1, MODE_IMM, OP_ORA};
            8'h05: d = '{1'b1, MODE_ZP, OP_ORA};
            8'h15: d = '{1'b1, MODE_ZPX, OP_ORA};
            8'h0D: d = '{1'b1, MODE_ABS, OP_ORA};
            8'h1D: d = '{1'b1, MODE_ABSX, OP_ORA};
            8'h19: d = '{1'b1, MODE_ABSY, OP_ORA};
            8'h01: d = '{1'b1, MODE_INDX, OP_ORA};
            8'h11: d = '{1'b1, MODE_INDY, OP_ORA};
            8'h69: d = '{1'b1, MODE_IMM, OP_ADC};
            8'h65: d = '{1'b1, MODE_ZP, OP_ADC};
            8'h75: d = '{1'b1, MODE_ZPX, OP_ADC};
            8'h6D: d = '{1'b1, MODE_ABS, OP_ADC};
            8'h7D: d = '{1'b1, MODE_ABSX, OP_ADC};
            8'h79: d = '{1'b1, MODE_ABSY, OP_ADC};
            8'h61: d = '{1'b1, MODE_INDX, OP_ADC};
            8'h71: d = '{1'b1, MODE_INDY, OP_ADC};
            8'hE9: d = '{1'b1, MODE_IMM, OP_SBC};
            8'hE5: d = '{1'b1, MODE_ZP, OP_SBC};
            8'hF5: d = '{1'b1, MODE_ZPX, OP_SBC};
            8'hED: d = '{1'b1, MODE_ABS, OP_SBC};
            8'hFD: d = '{1'b1, MODE_ABSX, OP_SBC};
            8'hF9: d = '{1'b1, MODE_ABSY, OP_SBC};
            8'hE1: d = '{1'b1, MODE_INDX, OP_SBC};
            8'hF1: d = '{1'b1, MODE_INDY, OP_SBC};
            8'hC9: d = '{1'b1, MODE_IMM, OP_CMP};
            8'hC5: d = '{1'b1, MODE_ZP, OP_CMP};
            8'hD5: d = '{1'b1, MODE_ZPX, OP_CMP};
            8'hCD: d = '{1'b1, MODE_ABS, OP_CMP};
            8'hDD: d = '{1'b1, MODE_ABSX, OP_CMP};
            8'hD9: d = '{1'b1, MODE_ABSY, OP_CMP};
            8'hC1: d = '{1'b1, MODE_INDX, OP_CMP};
            8'hD1: d = '{1'b1, MODE_INDY, OP_CMP};
            8'hE0: d = '{1'b1, MODE_IMM, OP_CPX};
            8'hE4: d = '{1'b1, MODE_ZP, OP_CPX};
            8'hEC: d = '{1'b1, MODE_ABS, OP_CPX};
            8'hC0: d = '{1'b1, MODE_IMM, OP_CPY};
            8'hC4: d = '{1'b1, MODE_ZP, OP_CPY};
            8'hCC: d = '{1'b1, MODE_ABS, OP_CPY};
            8'h24: d = '{1'b1, MODE_ZP, OP_BIT};
            8'h2C: d = '{1'b1, MODE_ABS, OP_BIT};
            8'h85: d = '{1'b1, MODE_ZP, OP_STA};
            8'h95: d = '{1'b1, MODE_ZPX, OP_STA};
            8'h8D: d = '{1'b1, MODE_ABS, OP_STA};
            8'h9D: d = '{1'b1, MODE_ABSX, OP_STA};
            8'h99: d = '{1'b1, MODE_ABSY, OP_STA};
            8'h81: d = '{1'b1, MODE_INDX, OP_STA};
            8'h91: d = '{1'b1, MODE_INDY, OP_STA};
            8'h86: d = '{1'b1, MODE_ZP, OP_STX};
            8'h96: d = '{1'b1, MODE_ZPY, OP_STX};
            8'h8E: d = '{1'b1, MODE_ABS, OP_STX};
            8'h84: d = '{1'b1, MODE_ZP, OP_STY};
            8'h94: d = '{1'b1, MODE_ZPX, OP_STY};
            8'h8C: d = '{1'b1, MODE_ABS, OP_STY};
            default: d.legal = 1'b0;
        endcase
        return d;
    endfunction

    function automatic logic [2:0] final_cycle(input t_mode m);
        logic [2:0] f;
        case (m)
            MODE_IMM:                       f = 3'd1;
            MODE_ZP:                        f = 3'd2;
            MODE_ZPX, MODE_ZPY, MODE_ABS:   f = 3'd3;
            MODE_ABSX, MODE_ABSY:           f = 3'd4;
            default:                        f = 3'd5;
        endcase
        return f;
    endfunction

endpackage

// ===== src/cycle_stepped_6502_core_subset.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cycle_stepped_6502_core_subset
// An accepted bus-cycle transaction's result is registered on the outputs.
// Throughput: one transaction per clock unless stalled; the step logic sits
// between the input byte and the registered result, with no other loop.
// Reset: synchronous active low; registers clear, first transaction fetches
// the opcode at start_address.
// ----------------------------------------------------------------------------
module cycle_stepped_6502_core_subset #(
    parameter logic [15:0] START_RESET = c6502_pkg::START_ADDRESS_RESET
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_read_data,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [15:0] o_bus_address,
    output logic        o_bus_write,
    output logic [7:0]  o_write_value,
    output logic        o_opcode_fetch,
    output logic        o_illegal_opcode,
    output logic [7:0]  o_acc_value,
    output logic [7:0]  o_index_x_value,
    output logic [7:0]  o_index_y_value,
    output logic [7:0]  o_status_value,
    output logic [15:0] o_program_counter
);

    logic [15:0] r_start;
    logic [15:0] r_pc, n_pc;
    logic [7:0]  r_a, n_a, r_x, n_x, r_y, n_y, r_p, n_p;
    logic [2:0]  r_cyc, n_cyc;
    logic [15:0] r_ea, n_ea, r_opl, n_opl;
    logic        r_pcf, n_pcf, r_done, n_done, r_pend;
    c6502_pkg::t_mode r_mode, n_mode;
    c6502_pkg::t_op   r_op, n_op;
    logic [7:0]  alu_a, alu_x, alu_y, alu_p;
    logic        do_exec;
    c6502_pkg::t_decode dec;
    logic        is_store, idx_abs, use_y, illegal;
    logic [7:0]  idx;
    logic [2:0]  fin;
    logic [8:0]  low;
    logic [15:0] addr;
    logic        wr;
    logic [7:0]  wval;
    logic        accept;

    assign accept      = i_valid & ~o_stall;
    assign o_stall     = o_valid & i_stall;
    assign o_cfg_ready = 1'b1;

    c6502_alu u_alu (
        .i_op(r_op), .i_data(i_read_data), .i_acc(r_a), .i_x(r_x), .i_y(r_y),
        .i_flags(r_p), .o_acc(alu_a), .o_x(alu_x), .o_y(alu_y), .o_flags(alu_p)
    );

    assign dec      = c6502_pkg::decode(i_read_data);
    assign is_store = (r_op == c6502_pkg::OP_STA) || (r_op == c6502_pkg::OP_STX)
                      || (r_op == c6502_pkg::OP_STY);
    assign idx_abs  = (r_mode == c6502_pkg::MODE_ABSX) || (r_mode == c6502_pkg::MODE_ABSY);
    assign use_y    = (r_mode == c6502_pkg::MODE_ZPY) || (r_mode == c6502_pkg::MODE_ABSY)
                      || (r_mode == c6502_pkg::MODE_INDY);
    assign idx      = use_y ? r_y : r_x;
    assign fin      = c6502_pkg::final_cycle(r_mode);
    assign low      = (idx_abs ? {1'b0, r_ea[7:0]} : {1'b0, r_opl[7:0]}) + {1'b0, idx};

    always_comb begin
        n_pc = r_pc; n_a = r_a; n_x = r_x; n_y = r_y; n_p = r_p;
        n_cyc = r_cyc; n_ea = r_ea; n_opl = r_opl; n_pcf = r_pcf; n_done = r_done;
        n_mode = r_mode; n_op = r_op;
        illegal = 1'b0; do_exec = 1'b0;
        if (!r_pend) begin
            n_pc = r_start;
            n_done = 1'b1;
        end else if (r_done) begin
            n_pc = r_pc + 16'd1;
            if (dec.legal) begin
                n_mode = dec.mode; n_op = dec.op;
                n_done = 1'b0; n_cyc = 3'd1;
                n_ea = '0; n_opl = '0; n_pcf = 1'b0;
            end else begin
                illegal = 1'b1;
            end
        end else begin
            if (r_cyc == 3'd1) begin
                n_pc = r_pc + 16'd1;
                if (r_mode == c6502_pkg::MODE_IMM) begin
                    do_exec = 1'b1; n_done = 1'b1;
                end else begin
                    n_ea = {8'd0, i_read_data};
                end
            end else if (r_cyc > fin || r_mode > c6502_pkg::MODE_INDY) begin
                n_done = 1'b1;
            end else if (r_cyc == fin) begin
                do_exec = ~is_store; n_done = 1'b1;
            end else if (r_mode == c6502_pkg::MODE_ZPX || r_mode == c6502_pkg::MODE_ZPY
                         || (r_mode == c6502_pkg::MODE_INDX && r_cyc == 3'd2)) begin
                n_ea = {8'd0, r_ea[7:0] + idx};
            end else if (r_mode == c6502_pkg::MODE_ABS) begin
                n_ea = {i_read_data, r_ea[7:0]};
                n_pc = r_pc + 16'd1;
            end else if (r_mode == c6502_pkg::MODE_INDX) begin
                if (r_cyc == 3'd3) begin
                    n_opl = {8'd0, i_read_data};
                end else begin
                    n_opl = {i_read_data, r_opl[7:0]};
                    n_ea  = {i_read_data, r_opl[7:0]};
                end
            end else if ((idx_abs && r_cyc == 3'd2)
                         || (r_mode == c6502_pkg::MODE_INDY && r_cyc == 3'd3)) begin
                n_pcf = low[8];
                n_ea  = {i_read_data, low[7:0]};
                if (idx_abs) n_pc = r_pc + 16'd1;
            end else if (r_mode == c6502_pkg::MODE_INDY && r_cyc == 3'd2) begin
                n_opl = {8'd0, i_read_data};
            end else begin
                // first read at indexed address, maybe wrong page
                if (r_pcf) n_ea = r_ea + 16'h0100;
                else if (!is_store) begin
                    do_exec = 1'b1; n_done = 1'b1;
                end
            end
            if (!n_done) n_cyc = r_cyc + 3'd1;
        end
        if (do_exec) begin
            n_a = alu_a; n_x = alu_x; n_y = alu_y; n_p = alu_p;
        end
        if (n_done) n_cyc = 3'd0;
    end

    // bus access for the next state
    always_comb begin
        wr = 1'b0; wval = 8'd0;
        if (n_done) begin
            addr = n_pc;
        end else begin
            if (n_cyc == 3'd1 || (n_cyc == 3'd2 && (n_mode == c6502_pkg::MODE_ABS
                || n_mode == c6502_pkg::MODE_ABSX || n_mode == c6502_pkg::MODE_ABSY)))
                addr = n_pc;
            else if ((n_mode == c6502_pkg::MODE_INDX && n_cyc == 3'd4)
                     || (n_mode == c6502_pkg::MODE_INDY && n_cyc == 3'd3))
                addr = {8'd0, n_ea[7:0] + 8'd1};
            else
                addr = n_ea;
            if ((n_op == c6502_pkg::OP_STA || n_op == c6502_pkg::OP_STX
                 || n_op == c6502_pkg::OP_STY) && n_cyc == c6502_pkg::final_cycle(n_mode)) begin
                wr = 1'b1;
                wval = (n_op == c6502_pkg::OP_STA) ? n_a :
                       (n_op == c6502_pkg::OP_STX) ? n_x : n_y;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start <= START_RESET;
            r_pc <= START_RESET;
            r_a <= '0; r_x <= '0; r_y <= '0; r_p <= '0;
            r_cyc <= '0; r_ea <= '0; r_opl <= '0; r_pcf <= 1'b0;
            r_mode <= c6502_pkg::MODE_IMM; r_op <= c6502_pkg::OP_LDA;
            r_done <= 1'b1; r_pend <= 1'b0;
            o_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) r_start <= i_cfg_data;
            if (accept) begin
                r_pc <= n_pc; r_a <= n_a; r_x <= n_x; r_y <= n_y; r_p <= n_p;
                r_cyc <= n_cyc; r_ea <= n_ea; r_opl <= n_opl; r_pcf <= n_pcf;
                r_mode <= n_mode; r_op <= n_op; r_done <= n_done; r_pend <= 1'b1;
                o_valid <= 1'b1;
                o_bus_address <= addr;
                o_bus_write <= wr;
                o_write_value <= wval;
                o_opcode_fetch <= n_done;
                o_illegal_opcode <= illegal;
                o_acc_value <= n_a;
                o_index_x_value <= n_x;
                o_index_y_value <= n_y;
                o_status_value <= n_p;
                o_program_counter <= n_pc;
            end else if (!i_stall) begin
                o_valid <= 1'b0;
            end
        end
    end

endmodule

// ===== src/c6502_alu.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c6502_alu
// Data operation and flag update for loads, logic, add/subtract, compare, bit.
// ----------------------------------------------------------------------------
module c6502_alu (
    input  c6502_pkg::t_op i_op,
    input  logic [7:0]     i_data,
    input  logic [7:0]     i_acc,
    input  logic [7:0]     i_x,
    input  logic [7:0]     i_y,
    input  logic [7:0]     i_flags,
    output logic [7:0]     o_acc,
    output logic [7:0]     o_x,
    output logic [7:0]     o_y,
    output logic [7:0]     o_flags
);

    logic [7:0] addend;
    logic [8:0] sum;
    logic [7:0] cmp_reg;
    logic [8:0] diff;
    logic [7:0] nz_val;
    logic       set_nz;

    assign addend  = (i_op == c6502_pkg::OP_SBC) ? ~i_data : i_data;
    assign sum     = {1'b0, i_acc} + {1'b0, addend} + {8'd0, i_flags[0]};
    assign cmp_reg = (i_op == c6502_pkg::OP_CPX) ? i_x :
                     (i_op == c6502_pkg::OP_CPY) ? i_y : i_acc;
    assign diff    = {1'b0, cmp_reg} - {1'b0, i_data};

    always_comb begin
        o_acc   = i_acc;
        o_x     = i_x;
        o_y     = i_y;
        o_flags = i_flags;
        nz_val  = i_data;
        set_nz  = 1'b1;
        case (i_op)
            c6502_pkg::OP_LDA: o_acc = i_data;
            c6502_pkg::OP_LDX: o_x = i_data;
            c6502_pkg::OP_LDY: o_y = i_data;
            c6502_pkg::OP_AND: begin
                o_acc  = i_acc & i_data;
                nz_val = o_acc;
            end
            c6502_pkg::OP_ORA: begin
                o_acc  = i_acc | i_data;
                nz_val = o_acc;
            end
            c6502_pkg::OP_EOR: begin
                o_acc  = i_acc ^ i_data;
                nz_val = o_acc;
            end
            c6502_pkg::OP_ADC, c6502_pkg::OP_SBC: begin
                o_acc      = sum[7:0];
                nz_val     = sum[7:0];
                o_flags[0] = sum[8];
                o_flags[6] = ~(i_acc[7] ^ addend[7]) & (i_acc[7] ^ sum[7]);
            end
            c6502_pkg::OP_CMP, c6502_pkg::OP_CPX, c6502_pkg::OP_CPY: begin
                nz_val     = diff[7:0];
                o_flags[0] = ~diff[8];
            end
            c6502_pkg::OP_BIT: begin
                set_nz     = 1'b0;
                o_flags[1] = ((i_acc & i_data) == 8'd0);
                o_flags[6] = i_data[6];
                o_flags[7] = i_data[7];
            end
            default: set_nz = 1'b0;
        endcase
        if (set_nz) begin
            o_flags[1] = (nz_val == 8'd0);
            o_flags[7] = nz_val[7];
        end
    end

endmodule

// ===== test/tb_cycle_stepped_6502_core_subset.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_cycle_stepped_6502_core_subset
// Drives bus-cycle transactions into the 6502 subset core. Opcodes and operand
// bytes are chosen from a cycle-stepped CPU predictor kept in this bench. Each
// presented bus access and register snapshot is checked against the predictor.
// ----------------------------------------------------------------------------
module tb_cycle_stepped_6502_core_subset;

    typedef struct packed {
        logic [15:0] addr;
        logic        wr;
        logic [7:0]  wval;
        logic        fetch;
        logic        illegal;
        logic [7:0]  a;
        logic [7:0]  x;
        logic [7:0]  y;
        logic [7:0]  p;
        logic [15:0] pc;
    } t_access;

    localparam int WATCHDOG_LIMIT = 5000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [15:0] i_cfg_data = 16'h0000;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [7:0]  i_read_data = 8'h00;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [15:0] o_bus_address;
    logic        o_bus_write;
    logic [7:0]  o_write_value;
    logic        o_opcode_fetch;
    logic        o_illegal_opcode;
    logic [7:0]  o_acc_value;
    logic [7:0]  o_index_x_value;
    logic [7:0]  o_index_y_value;
    logic [7:0]  o_status_value;
    logic [15:0] o_program_counter;

    cycle_stepped_6502_core_subset DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data),
        .i_valid(i_valid), .o_stall(o_stall), .i_read_data(i_read_data),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_bus_address(o_bus_address), .o_bus_write(o_bus_write),
        .o_write_value(o_write_value), .o_opcode_fetch(o_opcode_fetch),
        .o_illegal_opcode(o_illegal_opcode), .o_acc_value(o_acc_value),
        .o_index_x_value(o_index_x_value), .o_index_y_value(o_index_y_value),
        .o_status_value(o_status_value), .o_program_counter(o_program_counter)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // cpu predictor state
    logic [15:0] cpu_start = 16'h0000;
    logic [15:0] cpu_pc = 16'h0000;
    logic [7:0]  cpu_a = 8'h00, cpu_x = 8'h00, cpu_y = 8'h00, cpu_p = 8'h00;
    logic [2:0]  cpu_cyc = 3'd0;
    logic [15:0] cpu_ea = 16'h0000, cpu_opl = 16'h0000;
    logic        cpu_pcross = 1'b0;
    c6502_pkg::t_mode cpu_mode = c6502_pkg::MODE_IMM;
    c6502_pkg::t_op   cpu_op = c6502_pkg::OP_LDA;
    logic        cpu_done = 1'b1;
    logic        cpu_started = 1'b0;

    t_access     bus_expected[$];
    int          errors = 0;
    int          tx_idle_pct = 0;
    int          rx_stall_pct = 0;
    int          rx_hold_left = 0;

    // decode by the aaabbbcc opcode layout
    function automatic logic op_decode(input logic [7:0] code,
                                       output c6502_pkg::t_mode m,
                                       output c6502_pkg::t_op o);
        logic [2:0] aaa, bbb;
        logic ok;
        aaa = code[7:5];
        bbb = code[4:2];
        ok = 1'b0;
        m = c6502_pkg::MODE_IMM;
        o = c6502_pkg::OP_LDA;
        case (code[1:0])
            2'b01: begin
                ok = 1'b1;
                case (bbb)
                    3'd0: m = c6502_pkg::MODE_INDX;
                    3'd1: m = c6502_pkg::MODE_ZP;
                    3'd2: m = c6502_pkg::MODE_IMM;
                    3'd3: m = c6502_pkg::MODE_ABS;
                    3'd4: m = c6502_pkg::MODE_INDY;
                    3'd5: m = c6502_pkg::MODE_ZPX;
                    3'd6: m = c6502_pkg::MODE_ABSY;
                    default: m = c6502_pkg::MODE_ABSX;
                endcase
                case (aaa)
                    3'd0: o = c6502_pkg::OP_ORA;
                    3'd1: o = c6502_pkg::OP_AND;
                    3'd2: o = c6502_pkg::OP_EOR;
                    3'd3: o = c6502_pkg::OP_ADC;
                    3'd4: begin
                        o = c6502_pkg::OP_STA;
                        ok = (bbb != 3'd2);
                    end
                    3'd5: o = c6502_pkg::OP_LDA;
                    3'd6: o = c6502_pkg::OP_CMP;
                    default: o = c6502_pkg::OP_SBC;
                endcase
            end
            2'b10, 2'b00: begin
                case (bbb)
                    3'd0: m = c6502_pkg::MODE_IMM;
                    3'd1: m = c6502_pkg::MODE_ZP;
                    3'd3: m = c6502_pkg::MODE_ABS;
                    3'd5: m = code[1] ? c6502_pkg::MODE_ZPY : c6502_pkg::MODE_ZPX;
                    3'd7: m = code[1] ? c6502_pkg::MODE_ABSY : c6502_pkg::MODE_ABSX;
                    default: m = c6502_pkg::MODE_IMM;
                endcase
                if (code[1]) begin
                    if (aaa == 3'd5) begin
                        o = c6502_pkg::OP_LDX;
                        ok = bbb inside {3'd0, 3'd1, 3'd3, 3'd5, 3'd7};
                    end else if (aaa == 3'd4) begin
                        o = c6502_pkg::OP_STX;
                        ok = bbb inside {3'd1, 3'd3, 3'd5};
                    end
                end else begin
                    case (aaa)
                        3'd5: begin
                            o = c6502_pkg::OP_LDY;
                            ok = bbb inside {3'd0, 3'd1, 3'd3, 3'd5, 3'd7};
                        end
                        3'd4: begin
                            o = c6502_pkg::OP_STY;
                            ok = bbb inside {3'd1, 3'd3, 3'd5};
                        end
                        3'd6: begin
                            o = c6502_pkg::OP_CPY;
                            ok = bbb inside {3'd0, 3'd1, 3'd3};
                        end
                        3'd7: begin
                            o = c6502_pkg::OP_CPX;
                            ok = bbb inside {3'd0, 3'd1, 3'd3};
                        end
                        3'd1: begin
                            o = c6502_pkg::OP_BIT;
                            ok = bbb inside {3'd1, 3'd3};
                        end
                        default: ok = 1'b0;
                    endcase
                end
            end
            default: ok = 1'b0;
        endcase
        return ok;
    endfunction

    function automatic logic [2:0] last_cycle(input c6502_pkg::t_mode m);
        case (m)
            c6502_pkg::MODE_IMM: return 3'd1;
            c6502_pkg::MODE_ZP: return 3'd2;
            c6502_pkg::MODE_ZPX, c6502_pkg::MODE_ZPY, c6502_pkg::MODE_ABS: return 3'd3;
            c6502_pkg::MODE_ABSX, c6502_pkg::MODE_ABSY: return 3'd4;
            default: return 3'd5;
        endcase
    endfunction

    function automatic logic is_store();
        return cpu_op inside {c6502_pkg::OP_STA, c6502_pkg::OP_STX, c6502_pkg::OP_STY};
    endfunction

    function automatic logic [7:0] index_reg();
        return (cpu_mode inside {c6502_pkg::MODE_ZPY, c6502_pkg::MODE_ABSY,
                                 c6502_pkg::MODE_INDY}) ? cpu_y : cpu_x;
    endfunction

    function automatic logic [7:0] nz(input logic [7:0] f, input logic [7:0] v);
        logic [7:0] r;
        r = f & ~8'h82;
        if (v == 8'h00) r = r | 8'h02;
        return r | (v & 8'h80);
    endfunction

    function automatic void alu_add(input logic [7:0] d);
        logic [8:0] sum;
        logic [7:0] f;
        sum = {1'b0, cpu_a} + {1'b0, d} + {8'h00, cpu_p[0]};
        f = nz(cpu_p, sum[7:0]) & ~8'h41;
        f[0] = sum[8];
        f[6] = ~(cpu_a[7] ^ d[7]) & (cpu_a[7] ^ sum[7]);
        cpu_p = f;
        cpu_a = sum[7:0];
    endfunction

    function automatic void alu_compare(input logic [7:0] r, input logic [7:0] d);
        logic [7:0] f;
        f = nz(cpu_p, r - d);
        f[0] = (r >= d);
        cpu_p = f;
    endfunction

    function automatic void finish_insn(input logic [7:0] d);
        logic [7:0] f;
        if (!is_store()) begin
            case (cpu_op)
                c6502_pkg::OP_LDA: begin cpu_a = d; cpu_p = nz(cpu_p, d); end
                c6502_pkg::OP_LDX: begin cpu_x = d; cpu_p = nz(cpu_p, d); end
                c6502_pkg::OP_LDY: begin cpu_y = d; cpu_p = nz(cpu_p, d); end
                c6502_pkg::OP_AND: begin cpu_a = cpu_a & d; cpu_p = nz(cpu_p, cpu_a); end
                c6502_pkg::OP_ORA: begin cpu_a = cpu_a | d; cpu_p = nz(cpu_p, cpu_a); end
                c6502_pkg::OP_EOR: begin cpu_a = cpu_a ^ d; cpu_p = nz(cpu_p, cpu_a); end
                c6502_pkg::OP_ADC: alu_add(d);
                c6502_pkg::OP_SBC: alu_add(~d);
                c6502_pkg::OP_CMP: alu_compare(cpu_a, d);
                c6502_pkg::OP_CPX: alu_compare(cpu_x, d);
                c6502_pkg::OP_CPY: alu_compare(cpu_y, d);
                c6502_pkg::OP_BIT: begin
                    f = cpu_p & ~8'hC2;
                    if ((cpu_a & d) == 8'h00) f = f | 8'h02;
                    cpu_p = f | (d & 8'hC0);
                end
                default: ;
            endcase
        end
        cpu_done = 1'b1;
    endfunction

    function automatic void advance_cycle(input logic [7:0] d);
        logic [2:0] c;
        logic       idx_abs;
        logic [8:0] low;
        c = cpu_cyc;
        idx_abs = cpu_mode inside {c6502_pkg::MODE_ABSX, c6502_pkg::MODE_ABSY};
        if (c == 3'd1) begin
            cpu_pc = cpu_pc + 16'd1;
            if (cpu_mode == c6502_pkg::MODE_IMM) begin
                finish_insn(d);
                return;
            end
            cpu_ea = {8'h00, d};
        end else if (c > last_cycle(cpu_mode)) begin
            cpu_done = 1'b1;
        end else if (c == last_cycle(cpu_mode)) begin
            finish_insn(d);
        end else if (cpu_mode inside {c6502_pkg::MODE_ZPX, c6502_pkg::MODE_ZPY} ||
                     (cpu_mode == c6502_pkg::MODE_INDX && c == 3'd2)) begin
            cpu_ea = {8'h00, cpu_ea[7:0] + index_reg()};
        end else if (cpu_mode == c6502_pkg::MODE_ABS) begin
            cpu_ea = cpu_ea | {d, 8'h00};
            cpu_pc = cpu_pc + 16'd1;
        end else if (cpu_mode == c6502_pkg::MODE_INDX) begin
            if (c == 3'd3) begin
                cpu_opl = {8'h00, d};
            end else begin
                cpu_opl = cpu_opl | {d, 8'h00};
                cpu_ea = cpu_opl;
            end
        end else if ((idx_abs && c == 3'd2) ||
                     (cpu_mode == c6502_pkg::MODE_INDY && c == 3'd3)) begin
            low = {1'b0, idx_abs ? cpu_ea[7:0] : cpu_opl[7:0]} + {1'b0, index_reg()};
            cpu_pcross = low[8];
            cpu_ea = {d, low[7:0]};
            if (idx_abs) cpu_pc = cpu_pc + 16'd1;
        end else if (cpu_mode == c6502_pkg::MODE_INDY && c == 3'd2) begin
            cpu_opl = {8'h00, d};
        end else begin
            // first read at the indexed address, maybe from the wrong page
            if (cpu_pcross) cpu_ea = cpu_ea + 16'h0100;
            else if (!is_store()) finish_insn(d);
        end
        if (!cpu_done) cpu_cyc = cpu_cyc + 3'd1;
    endfunction

    function automatic t_access cpu_step(input logic [7:0] d);
        t_access r;
        c6502_pkg::t_mode m;
        c6502_pkg::t_op o;
        r = '0;
        if (!cpu_started) begin
            cpu_pc = cpu_start;
            cpu_done = 1'b1;
            cpu_started = 1'b1;
        end else if (cpu_done) begin
            cpu_pc = cpu_pc + 16'd1;
            if (op_decode(d, m, o)) begin
                cpu_mode = m;
                cpu_op = o;
                cpu_done = 1'b0;
                cpu_cyc = 3'd1;
                cpu_ea = '0;
                cpu_opl = '0;
                cpu_pcross = 1'b0;
            end else begin
                r.illegal = 1'b1;
            end
        end else begin
            advance_cycle(d);
        end
        if (cpu_done) begin
            cpu_cyc = 3'd0;
            r.addr = cpu_pc;
            r.fetch = 1'b1;
        end else begin
            if (cpu_cyc == 3'd1 ||
                (cpu_cyc == 3'd2 && cpu_mode inside {c6502_pkg::MODE_ABS,
                                                     c6502_pkg::MODE_ABSX,
                                                     c6502_pkg::MODE_ABSY}))
                r.addr = cpu_pc;
            else if ((cpu_mode == c6502_pkg::MODE_INDX && cpu_cyc == 3'd4) ||
                     (cpu_mode == c6502_pkg::MODE_INDY && cpu_cyc == 3'd3))
                r.addr = {8'h00, cpu_ea[7:0] + 8'h01};
            else
                r.addr = cpu_ea;
            if (is_store() && cpu_cyc == last_cycle(cpu_mode)) begin
                r.wr = 1'b1;
                r.wval = (cpu_op == c6502_pkg::OP_STA) ? cpu_a :
                         (cpu_op == c6502_pkg::OP_STX) ? cpu_x : cpu_y;
            end
        end
        r.a = cpu_a;
        r.x = cpu_x;
        r.y = cpu_y;
        r.p = cpu_p;
        r.pc = cpu_pc;
        return r;
    endfunction

    // receiver: random stall plus an optional long hold-off
    always @(posedge i_clk) begin
        if (rx_hold_left > 0) begin
            i_stall <= 1'b1;
            rx_hold_left <= rx_hold_left - 1;
        end else begin
            i_stall <= ($urandom_range(99) < rx_stall_pct);
        end
    end

    task automatic check_field(input string name, input logic [15:0] exp_v,
                               input logic [15:0] act_v);
        if (exp_v !== act_v) begin
            errors++;
            $display("%0t ns: %s mismatch, expected %h, got %h", $time, name, exp_v, act_v);
        end
    endtask

    always @(posedge i_clk) begin
        t_access e;
        if (i_rst_n && o_valid && !i_stall) begin
            if (bus_expected.size() == 0) begin
                errors++;
                $display("%0t ns: unexpected transaction, expected none, got address %h",
                         $time, o_bus_address);
            end else begin
                e = bus_expected.pop_front();
                check_field("bus_address", e.addr, o_bus_address);
                check_field("bus_write", 16'(e.wr), 16'(o_bus_write));
                check_field("write_value", 16'(e.wval), 16'(o_write_value));
                check_field("opcode_fetch", 16'(e.fetch), 16'(o_opcode_fetch));
                check_field("illegal_opcode", 16'(e.illegal), 16'(o_illegal_opcode));
                check_field("acc_value", 16'(e.a), 16'(o_acc_value));
                check_field("index_x_value", 16'(e.x), 16'(o_index_x_value));
                check_field("index_y_value", 16'(e.y), 16'(o_index_y_value));
                check_field("status_value", 16'(e.p), 16'(o_status_value));
                check_field("program_counter", e.pc, o_program_counter);
            end
        end
    end

    int idle_cycles = 0;
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // called right after a rising edge; returns right after the accepting edge
    task automatic send_byte(input logic [7:0] d);
        if ($urandom_range(99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < tx_idle_pct);
        end
        bus_expected.push_back(cpu_step(d));
        i_valid <= 1'b1;
        i_read_data <= d;
        do @(posedge i_clk); while (o_stall);
    endtask

    task automatic go_quiet();
        i_valid <= 1'b0;
        while (bus_expected.size() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic write_start(input logic [15:0] v);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        cpu_start = v;
    endtask

    function automatic logic [7:0] pick_byte();
        logic [7:0] b;
        c6502_pkg::t_mode m;
        c6502_pkg::t_op o;
        if (cpu_started && cpu_done && $urandom_range(99) < 88) begin
            do b = 8'($urandom_range(255)); while (!op_decode(b, m, o));
            return b;
        end
        case ($urandom_range(3))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    task automatic test_reset_and_start();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // only the value present at the first transaction after reset is used
        write_start(16'h1234);
        write_start(16'hFFFF);
    endtask

    task automatic test_directed();
        logic [7:0] prog[$];
        // wrapping fetch, loads, page-crossing indexed reads, pointer wrap,
        // an illegal opcode, indexed store, adc and bit
        prog = '{8'hFF, 8'hA2, 8'h01, 8'hBD, 8'hFF, 8'hFF, 8'h80, 8'h7F,
                 8'hB1, 8'hFF, 8'h10, 8'hFF, 8'h02, 8'h69, 8'h01, 8'h81,
                 8'hFE, 8'h00, 8'h40, 8'h12, 8'hE9, 8'hFF, 8'h24, 8'h80, 8'hC0};
        foreach (prog[i]) send_byte(prog[i]);
        go_quiet();
    endtask

    task automatic test_random(input int tx_pct, input int rx_pct, input int count,
                               input logic [15:0] start_value);
        write_start(start_value);
        tx_idle_pct = tx_pct;
        rx_stall_pct = rx_pct;
        repeat (count) send_byte(pick_byte());
        go_quiet();
    endtask

    task automatic test_backpressure();
        tx_idle_pct = 0;
        rx_stall_pct = 0;
        rx_hold_left = 60;
        repeat (40) send_byte(pick_byte());
        go_quiet();
    endtask

    initial begin
        test_reset_and_start();
        test_directed();
        test_random(0, 0, 150, 16'h0000);
        test_random(56, 0, 130, 16'($urandom_range(16'hFFFF)));
        test_random(0, 56, 130, 16'hFFFF);
        test_random(11, 11, 130, 16'h0000);
        test_backpressure();
        rx_stall_pct = 0;
        repeat (5) @(posedge i_clk);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
